// ===== rtl/ccbs_pkg.sv =====
// Shared constants and types for the console control byte sanitizer.
package ccbs_pkg;

	localparam logic [7:0] LEAD_BYTE   = 8'hC2;
	localparam logic [7:0] C1_LOW      = 8'h80;
	localparam logic [7:0] C1_HIGH     = 8'h9F;
	localparam logic [7:0] LF_BYTE     = 8'h0A;
	localparam logic [7:0] TAB_BYTE    = 8'h09;
	localparam logic [7:0] CR_BYTE     = 8'h0D;
	localparam logic [7:0] SPACE_BYTE  = 8'h20;
	localparam logic [7:0] DEL_BYTE    = 8'h7F;
	localparam logic [7:0] CTRL_OFFSET = 8'h40;
	localparam logic [7:0] CARET_BYTE  = 8'h5E;
	localparam logic [7:0] QMARK_BYTE  = 8'h3F;
	localparam logic [7:0] LBRACK_BYTE = 8'h5B;
	localparam logic [7:0] C_BYTE      = 8'h43;
	localparam logic [7:0] ONE_BYTE    = 8'h31;
	localparam logic [7:0] RBRACK_BYTE = 8'h5D;

	localparam int MAX_BYTES = 4;

	// Action codes of an input transfer.
	localparam logic ACT_DATA  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// Expansion of one input item: bytes in send order, count and next lead state.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      lead;
	} ccbs_exp_t;

endpackage

// ===== rtl/console_control_byte_sanitizer.sv =====
// Top level of the console control byte sanitizer.
// Usage: raw text bytes enter on the input channel (in_valid/in_ready with
// action and data_byte); terminal-safe bytes leave on the output channel
// (out_valid/out_ready with out_byte and last). Each input transfer causes
// zero to four output transfers, and last marks the final one of them.
// An end-of-stream transfer (action high) flushes a held 0xC2 lead byte.
// The first output byte of an item is offered once the item has passed the
// expansion register into the serializer. Throughput: one input transfer per
// cycle while each item yields at most one byte and out_ready stays high;
// otherwise the output port, one byte per cycle while out_ready, sets the rate.
// The expansion register sits between the two sides, so a new item is taken
// while the serializer still sends the bytes of the previous one.
// Items that yield no bytes (a carriage return, a held lead, an idle flush)
// are consumed and leave nothing in the expansion register.
// Reset clears the held lead byte and empties both registers.
// When the receiver stalls, the current byte holds steady, the expansion
// register fills, and in_ready then drops until the serializer frees up.
module console_control_byte_sanitizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last
);
	import ccbs_pkg::*;

	ccbs_exp_t expansion;

	logic                      lead_q;
	logic                      exp_valid_s1;
	logic [MAX_BYTES-1:0][7:0] exp_bytes_s1;
	logic [2:0]                exp_cnt_s1;
	logic [MAX_BYTES-1:0][7:0] ser_bytes_q;
	logic [2:0]                ser_cnt_q;
	logic [1:0]                ser_idx_q;

	logic in_xfer;
	logic out_xfer;
	logic ser_free;
	logic load;

	ccbs_expand u_expand (
		.action       (action),
		.data_byte    (data_byte),
		.lead_pending (lead_q),
		.expansion    (expansion)
	);

	// The serializer is free when empty or when its final byte leaves now.
	assign out_valid = (ser_cnt_q != 3'd0);
	assign last      = (ser_cnt_q == 3'd1);
	assign out_byte  = ser_bytes_q[ser_idx_q];
	assign out_xfer  = out_valid && out_ready;
	assign ser_free  = !out_valid || (out_xfer && last);
	assign load      = exp_valid_s1 && ser_free;
	assign in_ready  = !exp_valid_s1 || load;
	assign in_xfer   = in_valid && in_ready;

	// Control state: held lead byte, expansion valid, serializer position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q       <= 1'b0;
			exp_valid_s1 <= 1'b0;
			ser_cnt_q    <= 3'd0;
			ser_idx_q    <= 2'd0;
		end else begin
			if (in_xfer) begin
				lead_q <= expansion.lead;
			end
			if (load) begin
				exp_valid_s1 <= 1'b0;
			end
			if (in_xfer && expansion.cnt != 3'd0) begin
				exp_valid_s1 <= 1'b1;
			end
			if (load) begin
				ser_cnt_q <= exp_cnt_s1;
				ser_idx_q <= 2'd0;
			end else if (out_xfer) begin
				ser_cnt_q <= ser_cnt_q - 3'd1;
				ser_idx_q <= ser_idx_q + 2'd1;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			exp_bytes_s1 <= expansion.bytes;
			exp_cnt_s1   <= expansion.cnt;
		end
		if (load) begin
			ser_bytes_q <= exp_bytes_s1;
		end
	end

endmodule

// ===== rtl/ccbs_expand.sv =====
// Combinational expansion of one input item into up to four output bytes.
module ccbs_expand (
	input  logic                action,
	input  logic [7:0]          data_byte,
	input  logic                lead_pending,
	output ccbs_pkg::ccbs_exp_t expansion
);
	import ccbs_pkg::*;

	logic [7:0] p_b0;
	logic [7:0] p_b1;
	logic [1:0] p_cnt;
	logic       p_lead;
	logic       is_c1;

	assign is_c1 = (data_byte >= C1_LOW) && (data_byte <= C1_HIGH);

	// Handling of a byte with no lead byte in front of it.
	always_comb begin
		p_b0   = '0;
		p_b1   = '0;
		p_cnt  = 2'd0;
		p_lead = 1'b0;
		priority if (data_byte == LEAD_BYTE) begin
			p_lead = 1'b1;
		end else if (data_byte == LF_BYTE || data_byte == TAB_BYTE) begin
			p_b0  = data_byte;
			p_cnt = 2'd1;
		end else if (data_byte == CR_BYTE) begin
			p_cnt = 2'd0;
		end else if (data_byte < SPACE_BYTE) begin
			p_b0  = CARET_BYTE;
			p_b1  = data_byte + CTRL_OFFSET;
			p_cnt = 2'd2;
		end else if (data_byte == DEL_BYTE) begin
			p_b0  = CARET_BYTE;
			p_b1  = QMARK_BYTE;
			p_cnt = 2'd2;
		end else begin
			p_b0  = data_byte;
			p_cnt = 2'd1;
		end
	end

	always_comb begin
		expansion       = '0;
		expansion.lead  = lead_pending;
		priority if (action == ACT_FLUSH) begin
			if (lead_pending) begin
				expansion.bytes[0] = LEAD_BYTE;
				expansion.cnt      = 3'd1;
				expansion.lead     = 1'b0;
			end
		end else if (lead_pending) begin
			if (is_c1) begin
				expansion.bytes[0] = LBRACK_BYTE;
				expansion.bytes[1] = C_BYTE;
				expansion.bytes[2] = ONE_BYTE;
				expansion.bytes[3] = RBRACK_BYTE;
				expansion.cnt      = 3'd4;
				expansion.lead     = 1'b0;
			end else begin
				expansion.bytes[0] = LEAD_BYTE;
				expansion.bytes[1] = p_b0;
				expansion.bytes[2] = p_b1;
				expansion.cnt      = 3'd1 + {1'b0, p_cnt};
				expansion.lead     = p_lead;
			end
		end else begin
			expansion.bytes[0] = p_b0;
			expansion.bytes[1] = p_b1;
			expansion.cnt      = {1'b0, p_cnt};
			expansion.lead     = p_lead;
		end
	end

endmodule

// ===== rtl/ccbs_checker.sv =====
// Port-level checker for the console control byte sanitizer, with its bind.
module ccbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last
);

	// A stalled output byte holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output byte changed while stalled");

	// A byte that is not the last of its item is followed by more bytes.
	a_more_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("item ended without a last byte");

	// The input side only stalls while the output side has bytes to send.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with nothing to send");

	// The last flag is only shown together with a valid byte.
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> out_valid)
		else $error("last raised without a valid byte");

endmodule

bind console_control_byte_sanitizer ccbs_checker u_ccbs_checker (.*);
